[design/psd_pkg.sv]
package psd_pkg;
  localparam int MAX_PAIRS_DEF = 64;
  localparam int ID_BITS_DEF = 16;
  localparam int FIELD_W = 16;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SEARCH,
    ST_SHIFT,
    ST_EMIT_RD,
    ST_EMIT,
    ST_EMPTY
  } psd_state_t;

  // controller -> datapath
  typedef struct packed {
    logic load;       // capture input pair, clear search index
    logic search_step;
    logic shift_step;
    logic place;      // write new pair at search position
    logic set_ovf;
    logic shift_prime; // read top entry, point shift at count
    logic emit_rd;    // issue read of next entry
    logic emit_load;  // load output register from read data
    logic emit_empty; // load output register with empty marker
    logic clear_list;
  } psd_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic pair_valid;
    logic last_in;
    logic search_done;
    logic is_dup;
    logic full;
    logic shift_done;
    logic count_zero;
    logic emit_last;
    logic out_busy;
  } psd_status_t;
endpackage

[design/pair_sort_dedup_unit.sv]
// Pair sort and de-duplicate unit. Each input transaction carries one
// candidate pair of object identifiers (0 = absent); pairs with an absent
// member or equal members are dropped, the rest are normalised (low, high)
// and inserted in order into a store of MAX_PAIRS entries, duplicates
// skipped, extra unique pairs dropped with overflow flagged. After the
// transaction marked last_item, every held pair is sent out in ascending
// order, the final one marked last_result; an empty list gives one result
// with empty_list set. An inserted pair keeps the block busy through the
// accept, the search and the shift and place, because the store has a
// single read and write port that is walked one entry per cycle for the
// search and the shift; a duplicate or a pair dropped for lack of room
// takes only the accept and the search, and an invalid pair leaves from
// the search state without walking the store. Each result is then read
// from the store and loaded into the output register.
module pair_sort_dedup_unit #(
  parameter int MAX_PAIRS = psd_pkg::MAX_PAIRS_DEF,
  parameter int ID_BITS   = psd_pkg::ID_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [psd_pkg::FIELD_W-1:0]  in_first_id,
  input  logic [psd_pkg::FIELD_W-1:0]  in_second_id,
  input  logic                         in_last_item,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [psd_pkg::FIELD_W-1:0]  out_low_id,
  output logic [psd_pkg::FIELD_W-1:0]  out_high_id,
  output logic                         out_last_result,
  output logic                         out_empty_list,
  output logic                         out_overflowed
);
  import psd_pkg::*;

  psd_cmd_t    cmd;
  psd_status_t sts;

  psd_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready),
    .sts(sts), .cmd(cmd)
  );

  psd_dp #(.MAX_PAIRS(MAX_PAIRS), .ID_BITS(ID_BITS)) u_dp (
    .clk(clk), .rst_n(rst_n),
    .in_first_id(in_first_id), .in_second_id(in_second_id),
    .in_last_item(in_last_item), .cmd(cmd), .sts(sts),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_low_id(out_low_id), .out_high_id(out_high_id),
    .out_last_result(out_last_result), .out_empty_list(out_empty_list),
    .out_overflowed(out_overflowed)
  );
endmodule

[design/psd_ctrl.sv]
module psd_ctrl (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  psd_pkg::psd_status_t  sts,
  output psd_pkg::psd_cmd_t     cmd
);
  import psd_pkg::*;

  psd_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) state_nxt = ST_SEARCH;
      end
      ST_SEARCH: begin
        if (!sts.pair_valid) begin
          state_nxt = sts.last_in ? (sts.count_zero ? ST_EMPTY : ST_EMIT_RD) : ST_IDLE;
        end else if (sts.search_done) begin
          if (sts.is_dup || sts.full) begin
            state_nxt = sts.last_in ? (sts.count_zero ? ST_EMPTY : ST_EMIT_RD) : ST_IDLE;
          end else begin
            state_nxt = ST_SHIFT;
          end
        end
      end
      ST_SHIFT: begin
        if (sts.shift_done) state_nxt = sts.last_in ? ST_EMIT_RD : ST_IDLE;
      end
      ST_EMIT_RD: begin
        if (!sts.out_busy) state_nxt = ST_EMIT;
      end
      ST_EMIT: begin
        state_nxt = sts.emit_last ? ST_IDLE : ST_EMIT_RD;
      end
      ST_EMPTY: begin
        if (!sts.out_busy) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd = '0;
    in_ready = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        cmd.load = in_valid;
      end
      ST_SEARCH: begin
        cmd.search_step = sts.pair_valid && !sts.search_done;
        cmd.set_ovf = sts.pair_valid && sts.search_done && !sts.is_dup && sts.full;
        cmd.shift_prime = sts.pair_valid && sts.search_done && !sts.is_dup && !sts.full;
      end
      ST_SHIFT: begin
        cmd.shift_step = !sts.shift_done;
        cmd.place = sts.shift_done;
      end
      ST_EMIT_RD: begin
        cmd.emit_rd = !sts.out_busy;
      end
      ST_EMIT: begin
        cmd.emit_load = 1'b1;
        cmd.clear_list = sts.emit_last;
      end
      ST_EMPTY: begin
        cmd.emit_empty = !sts.out_busy;
        cmd.clear_list = !sts.out_busy;
      end
      default: ;
    endcase
  end
endmodule

[design/psd_dp.sv]
module psd_dp #(
  parameter int MAX_PAIRS = psd_pkg::MAX_PAIRS_DEF,
  parameter int ID_BITS   = psd_pkg::ID_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic [psd_pkg::FIELD_W-1:0]  in_first_id,
  input  logic [psd_pkg::FIELD_W-1:0]  in_second_id,
  input  logic                         in_last_item,
  input  psd_pkg::psd_cmd_t            cmd,
  output psd_pkg::psd_status_t         sts,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [psd_pkg::FIELD_W-1:0]  out_low_id,
  output logic [psd_pkg::FIELD_W-1:0]  out_high_id,
  output logic                         out_last_result,
  output logic                         out_empty_list,
  output logic                         out_overflowed
);
  import psd_pkg::*;

  localparam int IDX_W = $clog2(MAX_PAIRS);
  localparam int CNT_W = $clog2(MAX_PAIRS + 1);
  localparam int IW    = (ID_BITS < FIELD_W) ? ID_BITS : FIELD_W;
  localparam int PW    = 2 * IW;

  logic [PW-1:0] mem [MAX_PAIRS];
  logic [PW-1:0] rd_data_r;

  logic [IW-1:0]    lo_r, hi_r;
  logic             vld_r, last_r;
  logic [CNT_W-1:0] count_r, pos_r, ptr_r;
  logic             ovf_r;
  logic [CNT_W-1:0] emit_idx_r;

  logic [IW-1:0] a_m, b_m;
  assign a_m = in_first_id[IW-1:0];
  assign b_m = in_second_id[IW-1:0];

  logic [PW-1:0] key;
  assign key = {lo_r, hi_r};

  // Search walks the store one entry a cycle through the read port.
  logic [CNT_W-1:0] rd_addr;
  logic             rd_en;
  always_comb begin
    rd_en = 1'b0;
    rd_addr = pos_r;
    if (cmd.search_step || cmd.load) begin
      rd_en = 1'b1;
      rd_addr = cmd.load ? '0 : pos_r + 1'b1;
    end else if (cmd.shift_prime) begin
      rd_en = 1'b1;
      rd_addr = count_r - 1'b1;
    end else if (cmd.shift_step) begin
      rd_en = 1'b1;
      rd_addr = ptr_r - 2'd2;
    end else if (cmd.emit_rd) begin
      rd_en = 1'b1;
      rd_addr = emit_idx_r;
    end
  end

  // rd_data_r holds mem[pos_r] during search, mem[ptr_r-1] during shift
  logic at_end, less;
  assign at_end = (pos_r == count_r);
  assign less   = rd_data_r < key;
  assign sts.pair_valid  = vld_r;
  assign sts.last_in     = last_r;
  assign sts.search_done = at_end || !less;
  assign sts.is_dup      = !at_end && (rd_data_r == key);
  assign sts.full        = (count_r == CNT_W'(MAX_PAIRS));
  assign sts.shift_done  = (ptr_r == pos_r);
  assign sts.count_zero  = (count_r == '0);
  assign sts.emit_last   = (emit_idx_r == count_r);
  assign sts.out_busy    = out_valid && !out_ready;

  always_ff @(posedge clk) begin
    if (rd_en) rd_data_r <= mem[rd_addr[IDX_W-1:0]];
    if (cmd.shift_step) mem[ptr_r[IDX_W-1:0]] <= rd_data_r;
    else if (cmd.place) mem[pos_r[IDX_W-1:0]] <= key;
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      lo_r   <= (a_m < b_m) ? a_m : b_m;
      hi_r   <= (a_m < b_m) ? b_m : a_m;
      vld_r  <= (a_m != '0) && (b_m != '0) && (a_m != b_m);
      last_r <= in_last_item;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      ovf_r <= 1'b0;
      pos_r <= '0;
      ptr_r <= '0;
      emit_idx_r <= '0;
    end else begin
      if (cmd.load) pos_r <= '0;
      else if (cmd.search_step) pos_r <= pos_r + 1'b1;
      // shift starts at the top entry and walks down to the insert position
      if (cmd.load) ptr_r <= '0;
      else if (cmd.shift_prime) ptr_r <= count_r;
      else if (cmd.shift_step) ptr_r <= ptr_r - 1'b1;
      if (cmd.place) count_r <= count_r + 1'b1;
      if (cmd.set_ovf) ovf_r <= 1'b1;
      if (cmd.emit_rd) emit_idx_r <= emit_idx_r + 1'b1;
      if (cmd.clear_list) begin
        count_r <= '0;
        ovf_r <= 1'b0;
        emit_idx_r <= '0;
      end
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid <= 1'b0;
    end else if (cmd.emit_load || cmd.emit_empty) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit_load) begin
      out_low_id      <= FIELD_W'(rd_data_r[PW-1:IW]);
      out_high_id     <= FIELD_W'(rd_data_r[IW-1:0]);
      out_last_result <= sts.emit_last;
      out_empty_list  <= 1'b0;
      out_overflowed  <= ovf_r;
    end else if (cmd.emit_empty) begin
      out_low_id      <= '0;
      out_high_id     <= '0;
      out_last_result <= 1'b1;
      out_empty_list  <= 1'b1;
      out_overflowed  <= ovf_r;
    end
  end
endmodule

[design/psd_checker.sv]
module psd_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [15:0] out_low_id,
  input logic [15:0] out_high_id,
  input logic        out_last_result,
  input logic        out_empty_list
);
  a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_ready |=> in_valid)
    else $error("input transaction withdrawn");
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_low_id))
    else $error("result dropped while stalled");
  a_empty_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_empty_list |-> out_last_result && out_low_id == 16'd0)
    else $error("empty marker malformed");
  a_pair_order: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_empty_list |-> out_low_id < out_high_id)
    else $error("pair not normalised");
  a_no_in_while_out: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_last_result |-> !in_ready)
    else $error("input taken mid-run");
endmodule

bind pair_sort_dedup_unit psd_checker u_psd_checker (
  .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready),
  .out_valid(out_valid), .out_ready(out_ready), .out_low_id(out_low_id),
  .out_high_id(out_high_id), .out_last_result(out_last_result),
  .out_empty_list(out_empty_list)
);
